>>> rtl/utf8_to_json_ascii_escaper_defines.svh
// Assertion macros for the UTF-8 to JSON escaper.
// Needs clk and rst_n in the scope of each use; no other dependencies.
`ifndef UTF8_TO_JSON_ASCII_ESCAPER_DEFINES_SVH
`define UTF8_TO_JSON_ASCII_ESCAPER_DEFINES_SVH

`ifndef ASSERT_OFF
`define UJE_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("uje: implication check failed");
`define UJE_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("uje: next-cycle check failed");
`else
`define UJE_ASSERT_IMP(label, ante, cons)
`define UJE_ASSERT_NXT(label, ante, cons)
`endif

`endif

>>> rtl/uje_pkg.sv
// Shared types, character codes and the hex digit function for the escaper.
// No dependencies.
package uje_pkg;

  localparam int MaxChars = 6;
  localparam int CntW     = $clog2(MaxChars + 1);

  typedef logic [6:0] char_t;
  typedef logic [MaxChars-1:0][6:0] char_seq_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic [1:0] bytes_after;
  } in_item_t;

  typedef struct packed {
    logic [6:0] out_char;
    logic       run_last;
  } out_item_t;

  localparam logic [15:0] REPLACEMENT_CP = 16'hFFFD;

  localparam char_t CH_BSLASH = 7'h5C;
  localparam char_t CH_U      = 7'h75;
  localparam char_t CH_N      = 7'h6E;
  localparam char_t CH_R      = 7'h72;
  localparam char_t CH_T      = 7'h74;

  localparam logic [7:0] BYTE_QUOTE  = 8'h22;
  localparam logic [7:0] BYTE_BSLASH = 8'h5C;
  localparam logic [7:0] BYTE_LF     = 8'h0A;
  localparam logic [7:0] BYTE_CR     = 8'h0D;
  localparam logic [7:0] BYTE_TAB    = 8'h09;
  localparam logic [7:0] BYTE_DEL    = 8'h7F;

  // lowercase hex digit
  function automatic char_t hex_char(input logic [3:0] d);
    if (d < 4'd10) begin
      return 7'h30 + {3'b000, d};
    end else begin
      return 7'h57 + {3'b000, d};
    end
  endfunction

endpackage

>>> rtl/utf8_to_json_ascii_escaper.sv
// UTF-8 byte stream to JSON-escaped 7-bit ASCII, one character per result.
// Depends on uje_pkg and utf8_to_json_ascii_escaper_defines.svh.
//
// Usage:
//   in_valid/in_stall/in_data carry one UTF-8 byte per item together with
//   the count of bytes that follow it in the string (saturated at three).
//   out_valid/out_stall/out_data carry one ASCII character per item;
//   run_last marks the final character produced by an input byte.
//   A byte is decoded in the cycle it is accepted and its characters
//   (0, 1, 2 or 6 of them) land in a shift register that drives the output,
//   so the first character is offered in the cycle after acceptance.
//   Throughput: one byte per cycle while out_stall is low and each byte
//   yields at most one character; a byte yielding more characters holds
//   the input until all have left the single output shift register. The
//   next byte is taken in the same cycle as the last character leaves.
//   Continuation and lead bytes of multi-byte sequences yield nothing until
//   the sequence completes.
//   Reset clears the sequence state and empties the output register.
//   While out_stall is high the current character holds and in_stall rises
//   once the output register has characters in it.
`include "utf8_to_json_ascii_escaper_defines.svh"

module utf8_to_json_ascii_escaper
  import uje_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  logic [1:0]      absorb_r, absorb_nxt;
  logic [15:0]     code_r, code_nxt;
  logic            repl_r, repl_nxt;
  char_seq_t       seq_r, seq_nxt;
  logic [CntW-1:0] cnt_r, cnt_nxt;

  char_seq_t       dec_seq;
  logic [CntW-1:0] dec_cnt;
  logic            do_hex;
  logic [15:0]     hex_val;
  logic [15:0]     code_upd;
  logic [7:0]      c;
  logic [1:0]      after;
  logic            accept;
  logic            take;

  assign c     = in_data.data_byte;
  assign after = in_data.bytes_after;

  assign out_valid         = (cnt_r != '0);
  assign out_data.out_char = seq_r[0];
  assign out_data.run_last = (cnt_r == CntW'(1));

  // the last character leaving frees the register for the next byte
  assign in_stall = out_valid && !(!out_stall && cnt_r == CntW'(1));
  assign accept   = in_valid && !in_stall;
  assign take     = out_valid && !out_stall;

  always_comb begin
    dec_seq    = '0;
    dec_cnt    = '0;
    do_hex     = 1'b0;
    hex_val    = REPLACEMENT_CP;
    code_upd   = code_r;
    absorb_nxt = absorb_r;
    code_nxt   = code_r;
    repl_nxt   = repl_r;

    if (absorb_r != 2'd0) begin
      // continuation: taken whatever its value
      if (!repl_r) begin
        case (absorb_r)
          2'd1:    code_upd = code_r | {10'b0, c[5:0]};
          2'd2:    code_upd = code_r | {4'b0, c[5:0], 6'b0};
          default: code_upd = code_r | {c[3:0], 12'b0};
        endcase
      end
      absorb_nxt = absorb_r - 2'd1;
      if (absorb_r == 2'd1) begin
        do_hex   = 1'b1;
        hex_val  = repl_r ? REPLACEMENT_CP : code_upd;
        repl_nxt = 1'b0;
        code_nxt = '0;
      end else begin
        code_nxt = code_upd;
      end
    end else if (c inside {BYTE_QUOTE, BYTE_BSLASH}) begin
      dec_seq[0] = CH_BSLASH;
      dec_seq[1] = c[6:0];
      dec_cnt    = CntW'(2);
    end else if (c == BYTE_LF) begin
      dec_seq[0] = CH_BSLASH;
      dec_seq[1] = CH_N;
      dec_cnt    = CntW'(2);
    end else if (c == BYTE_CR) begin
      dec_seq[0] = CH_BSLASH;
      dec_seq[1] = CH_R;
      dec_cnt    = CntW'(2);
    end else if (c == BYTE_TAB) begin
      dec_seq[0] = CH_BSLASH;
      dec_seq[1] = CH_T;
      dec_cnt    = CntW'(2);
    end else if (c < 8'h20 || c == BYTE_DEL) begin
      do_hex  = 1'b1;
      hex_val = {8'h00, c};
    end else if (c < 8'h80) begin
      dec_seq[0] = c[6:0];
      dec_cnt    = CntW'(1);
    end else if ((c & 8'hE0) == 8'hC0 && after >= 2'd1) begin
      code_nxt   = {5'b0, c[4:0], 6'b0};
      repl_nxt   = 1'b0;
      absorb_nxt = 2'd1;
    end else if ((c & 8'hF0) == 8'hE0 && after >= 2'd2) begin
      code_nxt   = {c[3:0], 12'b0};
      repl_nxt   = 1'b0;
      absorb_nxt = 2'd2;
    end else if ((c & 8'hF8) == 8'hF0 && after == 2'd3) begin
      // four-byte sequence: swallowed, replaced at its end
      code_nxt   = '0;
      repl_nxt   = 1'b1;
      absorb_nxt = 2'd3;
    end else begin
      do_hex  = 1'b1;
      hex_val = REPLACEMENT_CP;
    end

    if (do_hex) begin
      dec_seq = {hex_char(hex_val[3:0]), hex_char(hex_val[7:4]),
                 hex_char(hex_val[11:8]), hex_char(hex_val[15:12]),
                 CH_U, CH_BSLASH};
      dec_cnt = CntW'(MaxChars);
    end
  end

  always_comb begin
    seq_nxt = seq_r;
    cnt_nxt = cnt_r;
    if (accept) begin
      seq_nxt = dec_seq;
      cnt_nxt = dec_cnt;
    end else if (take) begin
      seq_nxt = {7'h00, seq_r[MaxChars-1:1]};
      cnt_nxt = cnt_r - CntW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      absorb_r <= '0;
      code_r   <= '0;
      repl_r   <= 1'b0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (accept) begin
        absorb_r <= absorb_nxt;
        code_r   <= code_nxt;
        repl_r   <= repl_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    seq_r <= seq_nxt;
  end

  `UJE_ASSERT_IMP(a_idle_state_clear, absorb_r == 2'd0, code_r == 16'h0000 && !repl_r)
  `UJE_ASSERT_IMP(a_replace_no_code, repl_r, code_r == 16'h0000 && absorb_r != 2'd0)
  `UJE_ASSERT_IMP(a_cnt_range, 1'b1, cnt_r <= CntW'(MaxChars))
  `UJE_ASSERT_NXT(a_drain_step, take && cnt_r > CntW'(1), cnt_r == $past(cnt_r) - CntW'(1))

endmodule

>>> verif/utf8_to_json_ascii_escaper_tb.sv
// Self-checking testbench for utf8_to_json_ascii_escaper: directed and random UTF-8
// strings, a local escape predictor and in-order checking of every output item.
// Depends on uje_pkg and the escaper RTL only.
module utf8_to_json_ascii_escaper_tb;
  import uje_pkg::*;

  localparam int CycleLimit = 200000;
  localparam int LongHold   = 300;
  localparam logic [127:0] HexLut = "0123456789abcdef";

  logic      clk = 1'b0;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  // escaper state as the predictor sees it
  logic [1:0]  seq_left  = '0;
  logic [15:0] code_acc  = '0;
  logic        seq_bad   = 1'b0;

  out_item_t   exp_chars[$];
  logic [7:0]  text_bytes[$];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_left     = 0;
  int errors        = 0;
  int bytes_sent    = 0;
  int chars_checked = 0;
  int cycle_count   = 0;

  utf8_to_json_ascii_escaper dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("utf8_to_json_ascii_escaper_tb: errors");
      $finish;
    end
  end

  function automatic char_t hex_digit(input logic [3:0] d);
    return char_t'(HexLut[8 * (15 - d) +: 8]);
  endfunction

  // Works out the characters one accepted byte gives and queues them.
  function automatic void predict_escape(input in_item_t it);
    char_t       seq[6];
    int          n;
    int          shift;
    bit          hex;
    logic [15:0] cp;
    logic [7:0]  b;
    b   = it.data_byte;
    n   = 0;
    hex = 1'b0;
    cp  = '0;
    if (seq_left != 2'd0) begin
      // continuation: taken whatever its value or bytes_after
      if (!seq_bad) begin
        shift    = 6 * (int'(seq_left) - 1);
        code_acc = code_acc | (16'(b[5:0]) << shift);
      end
      seq_left = seq_left - 2'd1;
      if (seq_left == 2'd0) begin
        hex      = 1'b1;
        cp       = seq_bad ? REPLACEMENT_CP : code_acc;
        seq_bad  = 1'b0;
        code_acc = '0;
      end
    end else if (b inside {BYTE_QUOTE, BYTE_BSLASH}) begin
      seq[0] = CH_BSLASH; seq[1] = b[6:0]; n = 2;
    end else if (b == BYTE_LF) begin
      seq[0] = CH_BSLASH; seq[1] = CH_N; n = 2;
    end else if (b == BYTE_CR) begin
      seq[0] = CH_BSLASH; seq[1] = CH_R; n = 2;
    end else if (b == BYTE_TAB) begin
      seq[0] = CH_BSLASH; seq[1] = CH_T; n = 2;
    end else if (b < 8'h20 || b == BYTE_DEL) begin
      hex = 1'b1; cp = {8'h00, b};
    end else if (b < 8'h80) begin
      seq[0] = b[6:0]; n = 1;
    end else if (b[7:5] == 3'b110 && it.bytes_after >= 2'd1) begin
      code_acc = {5'b0, b[4:0], 6'b0}; seq_bad = 1'b0; seq_left = 2'd1;
    end else if (b[7:4] == 4'b1110 && it.bytes_after >= 2'd2) begin
      code_acc = {b[3:0], 12'b0}; seq_bad = 1'b0; seq_left = 2'd2;
    end else if (b[7:3] == 5'b11110 && it.bytes_after == 2'd3) begin
      code_acc = '0; seq_bad = 1'b1; seq_left = 2'd3;
    end else begin
      hex = 1'b1; cp = REPLACEMENT_CP;
    end
    if (hex) begin
      seq[0] = CH_BSLASH;
      seq[1] = CH_U;
      seq[2] = hex_digit(cp[15:12]);
      seq[3] = hex_digit(cp[11:8]);
      seq[4] = hex_digit(cp[7:4]);
      seq[5] = hex_digit(cp[3:0]);
      n = 6;
    end
    for (int i = 0; i < n; i++) begin
      exp_chars.push_back('{out_char: seq[i], run_last: (i == n - 1)});
    end
  endfunction

  // Receiver: random stall, or a counted long hold when one is requested.
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_stall = 1'b1;
      hold_left--;
    end else begin
      out_stall = ($urandom_range(99) < recv_idle_pct);
    end
  end

  always @(posedge clk) begin : check_chars
    out_item_t e;
    if (rst_n && out_valid && !out_stall) begin
      chars_checked++;
      if (exp_chars.size() == 0) begin
        $error("out_char %h arrived with nothing expected", out_data.out_char);
        errors++;
      end else begin
        e = exp_chars.pop_front();
        if (out_data.out_char !== e.out_char) begin
          $error("out_char: expected %h, got %h", e.out_char, out_data.out_char);
          errors++;
        end
        if (out_data.run_last !== e.run_last) begin
          $error("run_last: expected %b, got %b", e.run_last, out_data.run_last);
          errors++;
        end
      end
    end
  end

  // Called and returns at a falling edge; valid stays high for a following item.
  task automatic send_byte(input logic [7:0] b, input logic [1:0] n_after);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_data  = '{data_byte: b, bytes_after: n_after};
    do @(posedge clk); while (in_stall);
    predict_escape(in_data);
    bytes_sent++;
    @(negedge clk);
  endtask

  // Sends text_bytes as one string with true bytes_after counts, or random ones.
  task automatic send_text(input bit wild_counts);
    int rest;
    for (int i = 0; i < text_bytes.size(); i++) begin
      rest = text_bytes.size() - 1 - i;
      if (wild_counts) begin
        send_byte(text_bytes[i], 2'($urandom_range(3)));
      end else begin
        send_byte(text_bytes[i], (rest > 3) ? 2'd3 : 2'(rest));
      end
    end
    text_bytes.delete();
  endtask

  task automatic wait_drained();
    in_valid = 1'b0;
    while (exp_chars.size() != 0) @(negedge clk);
  endtask

  // One string of random characters; a tenth get random counts, a tenth lose a byte.
  task automatic send_random_string();
    int len;
    int mode;
    len  = $urandom_range(1, 10);
    mode = $urandom_range(9);
    for (int i = 0; i < len; i++) begin
      case ($urandom_range(9))
        0, 1, 2, 3: text_bytes.push_back(8'($urandom_range(8'h20, 8'h7E)));
        4: begin
          case ($urandom_range(4))
            0: text_bytes.push_back(BYTE_QUOTE);
            1: text_bytes.push_back(BYTE_BSLASH);
            2: text_bytes.push_back(BYTE_LF);
            3: text_bytes.push_back(BYTE_CR);
            default: text_bytes.push_back(BYTE_TAB);
          endcase
        end
        5: text_bytes.push_back(($urandom_range(7) == 0) ? BYTE_DEL :
                                8'($urandom_range(8'h1F)));
        6: begin
          text_bytes.push_back({3'b110, 5'($urandom)});
          text_bytes.push_back({2'b10, 6'($urandom)});
        end
        7: begin
          text_bytes.push_back({4'b1110, 4'($urandom)});
          text_bytes.push_back({2'b10, 6'($urandom)});
          // continuations are not checked, so any value may follow
          text_bytes.push_back(($urandom_range(3) == 0) ? 8'($urandom) :
                               {2'b10, 6'($urandom)});
        end
        8: begin
          text_bytes.push_back({5'b11110, 3'($urandom)});
          repeat (3) text_bytes.push_back({2'b10, 6'($urandom)});
        end
        default: text_bytes.push_back(8'($urandom));
      endcase
    end
    if (mode == 1 && text_bytes.size() > 1) void'(text_bytes.pop_back());
    send_text(mode == 0);
  endtask

  task automatic send_random_bytes(input int count);
    int start;
    start = bytes_sent;
    while (bytes_sent - start < count) send_random_string();
  endtask

  task automatic test_ascii_escapes();
    text_bytes = '{8'h00, BYTE_DEL, BYTE_QUOTE, BYTE_BSLASH, BYTE_LF, BYTE_CR,
                   BYTE_TAB, 8'h20, 8'h41, 8'h7E};
    send_text(1'b0);
  endtask

  task automatic test_multibyte();
    text_bytes = '{8'hC3, 8'hA9};
    send_text(1'b0);
    text_bytes = '{8'hE2, 8'h82, 8'hAC};
    send_text(1'b0);
    text_bytes = '{8'hF0, 8'h9F, 8'h98, 8'h80};
    send_text(1'b0);
  endtask

  task automatic test_malformed();
    send_byte(8'hC3, 2'd0);  // lead with nothing after it
    send_byte(8'hE2, 2'd1);  // three-byte lead with one byte after it
    send_byte(8'h80, 2'd0);  // stray continuation
    send_byte(8'hFF, 2'd3);  // stray high byte
    // string cut short: the next string's bytes are swallowed
    send_byte(8'hE2, 2'd2);
    send_byte(8'h41, 2'd1);
    send_byte(8'h42, 2'd0);
    wait_drained();
  endtask

  task automatic test_random_mix(input int send_pct, input int recv_pct, input int count);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    send_random_bytes(count);
    wait_drained();
  endtask

  task automatic test_output_hold();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_left     = LongHold;
    send_random_bytes(60);
    wait_drained();
  endtask

  task automatic test_drained_pause();
    send_idle_pct = 10;
    recv_idle_pct = 30;
    send_random_bytes(20);
    wait_drained();
    send_random_bytes(20);
    wait_drained();
  endtask

  initial begin
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_data  = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    send_idle_pct = 24;
    recv_idle_pct = 74;
    test_ascii_escapes();
    test_multibyte();
    test_malformed();
    test_random_mix(24, 74, 120);
    test_random_mix(74, 24, 120);
    test_random_mix(0, 0, 120);
    test_output_hold();
    test_drained_pause();

    wait_drained();
    repeat (20) @(negedge clk);
    if (exp_chars.size() != 0) begin
      $error("%0d expected characters never arrived", exp_chars.size());
      errors++;
    end
    $display("%0d bytes sent, %0d characters checked, %0d mismatches",
             bytes_sent, chars_checked, errors);
    $display("covered escapes, multi-byte and malformed input, three idle mixes, long hold");
    if (errors == 0) begin
      $display("utf8_to_json_ascii_escaper_tb: clean");
    end else begin
      $display("utf8_to_json_ascii_escaper_tb: errors");
    end
    $finish;
  end

endmodule
